// File: hdl/tlws_pkg.sv
// Shared constants, types and helper functions for the text statistics core.
package tlws_pkg;

    // Counter and result geometry
    localparam int COUNT_BITS  = 32;
    localparam int STAT_W      = 32;
    localparam int NUM_LETTERS = 26;
    localparam int NUM_STATS   = 28;
    localparam int IDX_W       = 5;
    localparam int SLOT_W      = 5;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [STAT_W-1:0]     t_stat;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [7:0]            t_byte;

    // Statistic indexes past the letters
    localparam t_idx IDX_WORDS     = IDX_W'(NUM_LETTERS);
    localparam t_idx IDX_SENTENCES = IDX_W'(NUM_STATS - 1);

    // Character codes
    localparam t_byte CH_NEWLINE = 8'h0A;
    localparam t_byte CH_COMMA   = 8'h2C;
    localparam t_byte CH_PERIOD  = 8'h2E;
    localparam t_byte CH_QUEST   = 8'h3F;
    localparam t_byte CH_EXCLAIM = 8'h21;
    localparam t_byte CH_SEMI    = 8'h3B;
    localparam t_byte CH_COLON   = 8'h3A;
    localparam t_byte CH_LOW_A   = 8'h61;
    localparam t_byte CH_LOW_Z   = 8'h7A;
    localparam t_byte CH_UP_A    = 8'h41;
    localparam t_byte CH_UP_Z    = 8'h5A;

    typedef struct packed {
        logic  hit;
        t_slot slot;
    } t_letter;

    // Map a byte to its case-insensitive letter slot
    function automatic t_letter decode_letter(input t_byte c);
        t_letter r;
        t_byte   d;
        r = '0;
        d = '0;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            d      = c - CH_LOW_A;
            r.hit  = 1'b1;
            r.slot = d[SLOT_W-1:0];
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d      = c - CH_UP_A;
            r.hit  = 1'b1;
            r.slot = d[SLOT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic is_mark(input t_byte c);
        return (c == CH_COMMA) || (c == CH_PERIOD) || (c == CH_QUEST) ||
               (c == CH_EXCLAIM) || (c == CH_SEMI) || (c == CH_COLON);
    endfunction

    // Saturating increment
    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    // Clamp a counter to the reported width
    function automatic t_stat to_stat(input t_count v);
        logic [STAT_W+COUNT_BITS-1:0] wide;
        wide = {{STAT_W{1'b0}}, v};
        if (|(wide >> STAT_W)) begin
            return '1;
        end
        return wide[STAT_W-1:0];
    endfunction

endpackage

// File: hdl/tlws_if.sv
// Ready/valid stream interfaces for text bytes in and statistics out.
interface tlws_in_if
    import tlws_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte char_byte;
    logic  char_valid;
    logic  report;

    modport source (output valid, output char_byte, output char_valid, output report,
                    input ready);
    modport sink   (input valid, input char_byte, input char_valid, input report,
                    output ready);
endinterface

interface tlws_out_if
    import tlws_pkg::*;
();
    logic  valid;
    logic  ready;
    t_idx  stat_index;
    t_stat stat_value;
    logic  last_stat;

    modport source (output valid, output stat_index, output stat_value, output last_stat,
                    input ready);
    modport sink   (input valid, input stat_index, input stat_value, input last_stat,
                    output ready);
endinterface

// File: hdl/text_letter_word_sentence_stats_core.sv
// Text statistics core: letter histogram, word and sentence counters with report walk.
//
// Usage:
// i_char carries one text byte per transaction with char_valid and report flags.
// A byte with char_valid low changes nothing. A newline ends the current word and
// clears the letter-seen flag for sentence marks.
// Letter counters live in a 26-entry synchronous RAM updated by read-modify-write:
// the read is issued when the byte is taken and the write lands in the next cycle,
// with the last written entry forwarded, so bytes are taken one per cycle outside walks.
// Word and sentence counters and the two flags are plain registers.
// A transaction with report set makes the core emit 28 results on o_stat:
// letters a..z (index 0..25), words (26), sentences (27, last_stat high).
// The report includes the byte carried by the same transaction.
// The walk starts with a drain state after the report transaction is taken; each
// result then takes a RAM read state and a load state, and loads while o_stat is
// ready. i_char.ready stays low for the whole walk.
// A stalled o_stat holds its result and pauses the walk; the next result loads at the
// edge that takes the held one.
// Reset clears the counters at once through per-entry valid bits on the RAM;
// there is no clearing pass. Counters saturate and are never cleared otherwise.
module text_letter_word_sentence_stats_core
    import tlws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tlws_in_if.sink    i_char,
    tlws_out_if.source o_stat
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DRAIN = 4'b0010,
        S_RD    = 4'b0100,
        S_LD    = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Letter counter RAM and per-entry valid bits
    t_count                 r_mem [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] r_lvld;
    t_count                 r_rd_data;
    logic                   r_rd_vld;

    // Write stage and forwarding
    logic   r_s1_vld;
    t_slot  r_s1_slot;
    logic   r_wr_vld;
    t_slot  r_wr_slot;
    t_count r_wr_data;

    // Scalar state
    t_count r_words, n_words;
    t_count r_sents, n_sents;
    logic   r_in_word, n_in_word;
    logic   r_lsm, n_lsm;

    // Report walk and output register
    t_idx  r_idx, n_idx;
    logic  r_out_vld, n_out_vld;
    t_idx  r_out_idx, n_out_idx;
    t_stat r_out_val, n_out_val;
    logic  r_out_last, n_out_last;

    logic    acc;
    t_letter let_d;
    logic    rd_en;
    t_slot   rd_slot;
    logic    s0_letter;
    t_count  s1_old;
    t_count  s1_new;
    logic    out_free;

    assign i_char.ready = (r_state == S_IDLE);
    assign acc          = i_char.valid && (r_state == S_IDLE);
    assign let_d        = decode_letter(i_char.char_byte);
    assign s0_letter    = acc && i_char.char_valid && let_d.hit;
    assign out_free     = !r_out_vld || o_stat.ready;

    // Pick the RAM read address: byte lookup or report walk
    always_comb begin
        rd_en   = 1'b0;
        rd_slot = let_d.slot;
        if (s0_letter) begin
            rd_en = 1'b1;
        end else if (r_state == S_RD && r_idx < IDX_WORDS) begin
            rd_en   = 1'b1;
            rd_slot = r_idx[SLOT_W-1:0];
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_slot];
            r_rd_vld  <= r_lvld[rd_slot];
        end
    end

    // Modify: forward the entry written last cycle
    always_comb begin
        if (r_wr_vld && r_wr_slot == r_s1_slot) begin
            s1_old = r_wr_data;
        end else if (r_rd_vld) begin
            s1_old = r_rd_data;
        end else begin
            s1_old = '0;
        end
        s1_new = sat_inc(s1_old);
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_mem[r_s1_slot] <= s1_new;
        end
        r_wr_slot <= r_s1_slot;
        r_wr_data <= s1_new;
        r_s1_slot <= let_d.slot;
    end

    // Valid bits and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld   <= '0;
            r_s1_vld <= 1'b0;
            r_wr_vld <= 1'b0;
        end else begin
            if (r_s1_vld) begin
                r_lvld[r_s1_slot] <= 1'b1;
            end
            r_s1_vld <= s0_letter;
            r_wr_vld <= r_s1_vld;
        end
    end

    // Word, sentence and flag updates for the taken byte
    always_comb begin
        n_words   = r_words;
        n_sents   = r_sents;
        n_in_word = r_in_word;
        n_lsm     = r_lsm;
        if (acc && i_char.char_valid) begin
            if (i_char.char_byte == CH_NEWLINE) begin
                n_in_word = 1'b0;
                n_lsm     = 1'b0;
            end else if (let_d.hit) begin
                if (!r_in_word) begin
                    n_words = sat_inc(r_words);
                end
                n_in_word = 1'b1;
                n_lsm     = 1'b1;
            end else begin
                n_in_word = 1'b0;
                if (is_mark(i_char.char_byte) && r_lsm) begin
                    n_sents = sat_inc(r_sents);
                    n_lsm   = 1'b0;
                end
            end
        end
    end

    // Report walk and output register
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_out_vld  = r_out_vld && !o_stat.ready;
        n_out_idx  = r_out_idx;
        n_out_val  = r_out_val;
        n_out_last = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (acc && i_char.report) begin
                    n_state = S_DRAIN;
                    n_idx   = '0;
                end
            end
            S_DRAIN: begin
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_idx  = r_idx;
                    n_out_last = (r_idx == IDX_SENTENCES);
                    if (r_idx == IDX_WORDS) begin
                        n_out_val = to_stat(r_words);
                    end else if (r_idx == IDX_SENTENCES) begin
                        n_out_val = to_stat(r_sents);
                    end else begin
                        n_out_val = to_stat(r_rd_vld ? r_rd_data : '0);
                    end
                    if (r_idx == IDX_SENTENCES) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
            r_words   <= '0;
            r_sents   <= '0;
            r_in_word <= 1'b0;
            r_lsm     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
            r_words   <= n_words;
            r_sents   <= n_sents;
            r_in_word <= n_in_word;
            r_lsm     <= n_lsm;
        end
    end

    // Output payload registers
    always_ff @(posedge i_clk) begin
        r_out_idx  <= n_out_idx;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
    end

    assign o_stat.valid      = r_out_vld;
    assign o_stat.stat_index = r_out_idx;
    assign o_stat.stat_value = r_out_val;
    assign o_stat.last_stat  = r_out_last;

endmodule
